[rtl/gal_pkg.sv]
`default_nettype none

package gal_pkg;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMMON,
      ST_STRIP_X,
      ST_REDUCE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_DONE
   } state_type;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ZERO,
      OP_HALVE_BOTH,
      OP_HALVE_X,
      OP_REDUCE,
      OP_FORM_GCD,
      OP_DIV_STEP,
      OP_MULTIPLY
   } op_type;

   // Flags the datapath reports back to the controller.
   typedef struct packed {
      logic either_zero;
      logic x_even;
      logic y_even;
      logic y_zero;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

[rtl/gal_ctrl.sv]
`default_nettype none

module gal_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  gal_pkg::status_type  status,
   output gal_pkg::op_type      op,
   output logic                 busy,
   output logic                 done
);

   gal_pkg::state_type state_ff;
   gal_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gal_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gal_pkg::ST_IDLE: begin
            if (start) state_in = gal_pkg::ST_COMMON;
         end
         gal_pkg::ST_COMMON: begin
            if (status.either_zero) state_in = gal_pkg::ST_DONE;
            else if (!(status.x_even && status.y_even)) state_in = gal_pkg::ST_STRIP_X;
         end
         gal_pkg::ST_STRIP_X: begin
            if (!status.x_even) state_in = gal_pkg::ST_REDUCE;
         end
         gal_pkg::ST_REDUCE: begin
            if (status.y_zero) state_in = gal_pkg::ST_DIVIDE;
         end
         gal_pkg::ST_DIVIDE: begin
            if (status.div_last) state_in = gal_pkg::ST_MULTIPLY;
         end
         gal_pkg::ST_MULTIPLY: begin
            state_in = gal_pkg::ST_DONE;
         end
         gal_pkg::ST_DONE: begin
            state_in = gal_pkg::ST_IDLE;
         end
         default: begin
            state_in = gal_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      op   = gal_pkg::OP_NONE;
      busy = 1'b1;
      done = 1'b0;
      unique case (state_ff)
         gal_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) op = gal_pkg::OP_LOAD;
         end
         gal_pkg::ST_COMMON: begin
            if (status.either_zero) op = gal_pkg::OP_ZERO;
            else if (status.x_even && status.y_even) op = gal_pkg::OP_HALVE_BOTH;
         end
         gal_pkg::ST_STRIP_X: begin
            if (status.x_even) op = gal_pkg::OP_HALVE_X;
         end
         gal_pkg::ST_REDUCE: begin
            if (status.y_zero) op = gal_pkg::OP_FORM_GCD;
            else op = gal_pkg::OP_REDUCE;
         end
         gal_pkg::ST_DIVIDE: begin
            op = gal_pkg::OP_DIV_STEP;
         end
         gal_pkg::ST_MULTIPLY: begin
            op = gal_pkg::OP_MULTIPLY;
         end
         gal_pkg::ST_DONE: begin
            done = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/gal_dp.sv]
`default_nettype none

module gal_dp #(
   parameter int OPERAND_BITS = 31
) (
   input  wire                         clock,
   input  gal_pkg::op_type             op,
   input  wire  [OPERAND_BITS-1:0]     operand_a,
   input  wire  [OPERAND_BITS-1:0]     operand_b,
   output gal_pkg::status_type         status,
   output logic [OPERAND_BITS-1:0]     divisor_result,
   output logic [2*OPERAND_BITS-1:0]   multiple_result,
   output logic                        both_zero
);

   localparam int N        = OPERAND_BITS;
   localparam int CNT_BITS = $clog2(N);

   logic [N-1:0]        a_ff, a_in, b_ff, b_in;
   logic [N-1:0]        x_ff, x_in, y_ff, y_in;
   logic [CNT_BITS-1:0] shift_ff, shift_in;
   logic [N-1:0]        g_ff, g_in;
   logic [N-1:0]        rem_ff, rem_in, quo_ff, quo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [2*N-1:0]      m_ff, m_in;
   logic                zero_ff, zero_in;

   logic                x_gt_y;
   logic [N-1:0]        diff_xy;
   logic [N:0]          partial;
   logic [N:0]          partial_diff;
   logic                fits;

   assign x_gt_y  = x_ff > y_ff;
   assign diff_xy = x_gt_y ? (x_ff - y_ff) : (y_ff - x_ff);

   // One restoring division step: shift the next dividend bit in, subtract when it fits.
   assign partial      = {rem_ff, quo_ff[N-1]};
   assign partial_diff = partial - {1'b0, g_ff};
   assign fits         = partial >= {1'b0, g_ff};

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      shift_in = shift_ff;
      g_in     = g_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      m_in     = m_ff;
      zero_in  = zero_ff;
      unique case (op)
         gal_pkg::OP_LOAD: begin
            a_in     = operand_a;
            b_in     = operand_b;
            x_in     = operand_a;
            y_in     = operand_b;
            shift_in = '0;
         end
         gal_pkg::OP_ZERO: begin
            g_in    = a_ff | b_ff;
            m_in    = '0;
            zero_in = (a_ff == '0) && (b_ff == '0);
         end
         gal_pkg::OP_HALVE_BOTH: begin
            x_in     = x_ff >> 1;
            y_in     = y_ff >> 1;
            shift_in = shift_ff + 1'b1;
         end
         gal_pkg::OP_HALVE_X: begin
            x_in = x_ff >> 1;
         end
         gal_pkg::OP_REDUCE: begin
            if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else begin
               x_in = x_gt_y ? y_ff : x_ff;
               y_in = diff_xy;
            end
         end
         gal_pkg::OP_FORM_GCD: begin
            g_in    = x_ff << shift_ff;
            rem_in  = '0;
            quo_in  = a_ff;
            cnt_in  = '0;
            zero_in = 1'b0;
         end
         gal_pkg::OP_DIV_STEP: begin
            rem_in = fits ? partial_diff[N-1:0] : partial[N-1:0];
            quo_in = {quo_ff[N-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
         end
         gal_pkg::OP_MULTIPLY: begin
            m_in = {{N{1'b0}}, quo_ff} * {{N{1'b0}}, b_ff};
         end
         default: begin
            m_in = m_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      shift_ff <= shift_in;
      g_ff     <= g_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      m_ff     <= m_in;
      zero_ff  <= zero_in;
   end

   assign status.either_zero = (a_ff == '0) || (b_ff == '0);
   assign status.x_even      = !x_ff[0];
   assign status.y_even      = !y_ff[0];
   assign status.y_zero      = (y_ff == '0);
   assign status.div_last    = (cnt_ff == CNT_BITS'(N - 1));

   assign divisor_result  = g_ff;
   assign multiple_result = m_ff;
   assign both_zero       = zero_ff;

endmodule

`default_nettype wire

[rtl/gcd_and_lcm.sv]
`default_nettype none

// Channel   Handshake                 Payload
// request   start, busy               req_operand_a, req_operand_b
// response  rsp_valid (strobe)        rsp_divisor_result, rsp_multiple_result, rsp_both_zero
//
// A beat is taken on a rising edge with start high and busy low; busy then stays high
// until the response strobe has been shown. Binary GCD strips common factors of two
// (one bit per cycle), strips the first operand, then runs a subtract-or-halve loop;
// a one-bit-per-cycle restoring divider forms a/g, and a single multiply step gives
// the multiple. A beat whose operand is zero skips the loop, the divider and the
// multiply. Reset is synchronous and clears only the controller. The receiver cannot
// stall: the response is valid for exactly one cycle.

module gcd_and_lcm #(
   parameter int OPERAND_BITS = 31
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire  [OPERAND_BITS-1:0]     req_operand_a,
   input  wire  [OPERAND_BITS-1:0]     req_operand_b,
   output logic                        rsp_valid,
   output logic [OPERAND_BITS-1:0]     rsp_divisor_result,
   output logic [2*OPERAND_BITS-1:0]   rsp_multiple_result,
   output logic                        rsp_both_zero
);

   gal_pkg::op_type     op;
   gal_pkg::status_type status;

   // The controller sequences the phases of the algorithm and owns the handshake.
   gal_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy),
      .done   (rsp_valid)
   );

   // The datapath holds the operands, the reduction pair, the divider and the
   // product; its result registers stay stable while the strobe is shown.
   gal_dp #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_dp (
      .clock           (clock),
      .op              (op),
      .operand_a       (req_operand_a),
      .operand_b       (req_operand_b),
      .status          (status),
      .divisor_result  (rsp_divisor_result),
      .multiple_result (rsp_multiple_result),
      .both_zero       (rsp_both_zero)
   );

   // An accepted beat makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a beat");

   // The response strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // The strobe only appears while a beat is in flight.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   // Both operands zero gives zero results.
   a_zero_results: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_both_zero) |-> (rsp_divisor_result == '0 && rsp_multiple_result == '0))
      else $error("both-zero response with nonzero results");

endmodule

`default_nettype wire
